/* design/nmea_pkg.sv */
package nmea_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TYPE_FILTER_ON      = 2'd0,
    REG_TYPE_PATTERN        = 2'd1,
    REG_TYPE_PATTERN_LENGTH = 2'd2,
    REG_FIELD_SPLIT_ON      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_TYPE = 3'd1,
    PH_BODY = 3'd2,
    PH_CK1  = 3'd3,
    PH_CK2  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] echo_byte;
    logic       in_sentence;
    logic [5:0] field_number;
    logic       field_closed;
    logic       sentence_good;
    logic       sentence_dropped;
    logic [5:0] fields_found;
    logic [7:0] running_check;
  } out_beat_t;

  // Uppercase-only hex digit; anything else wraps modulo 256.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c < CHAR_UPPER_A) begin
      return c - CHAR_ZERO;
    end
    return c - CHAR_UPPER_A + 8'd10;
  endfunction

endpackage

/* design/nmea_in_if.sv */
interface nmea_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

/* design/nmea_out_if.sv */
interface nmea_out_if;
  logic                 valid;
  logic                 ready;
  nmea_pkg::out_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/nmea_sentence_parser.sv */
// NMEA sentence parser with XOR checksum.
// The in_ch channel carries one received character per beat. The out_ch
// channel returns exactly one result beat per input beat, in order: the echoed
// byte, sentence and field markers, good or dropped flags, the field count and
// the running XOR of the sentence body.
// A byte accepted at one edge appears on out_ch right after that edge.
// Throughput is one byte per cycle unless out_ch stalls, set by the single
// result register; the parse state updates in the same cycle that a byte is
// accepted. When out_ch stalls with a result held, in_ch.ready drops until
// the result is taken; in the cycle it is taken a new byte can be accepted.
// The cfg_we, cfg_index and cfg_wdata port writes one register per edge and
// should be used only while no byte is in flight.
// Reset (rst_n low, synchronous) empties the result register, puts the parser
// in the state waiting for a dollar sign, clears the sums and counters and
// loads the register defaults: filter off, pattern zero, pattern length five,
// field splitting on.
module nmea_sentence_parser #(
  parameter int unsigned MAX_FIELDS    = 32,
  parameter int unsigned PATTERN_CHARS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  nmea_in_if.sink                             in_ch,
  nmea_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [nmea_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nmea_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [5:0] TALLY_MAX   = 6'(MAX_FIELDS);
  localparam logic [3:0] PAT_LEN_MAX = 4'(PATTERN_CHARS);
  localparam logic [3:0] POS_MAX     = 4'd15;

  logic                 type_filter_on_r;
  logic [63:0]          type_pattern_r;
  logic [3:0]           type_pattern_length_r;
  logic                 field_split_on_r;

  nmea_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           xor_sum_r, xor_sum_nxt;
  logic [7:0]           received_sum_r, received_sum_nxt;
  logic [3:0]           type_pos_r, type_pos_nxt;
  logic [5:0]           field_tally_r, field_tally_nxt;

  logic                 out_valid_r;
  nmea_pkg::out_beat_t  out_data_r, out_data_nxt;

  logic                 in_fire;
  logic [7:0]           c;
  logic                 is_dollar, is_comma, is_star, is_closer;
  logic                 in_text;
  logic [3:0]           pat_len;
  logic [7:0]           pat_char;
  logic                 type_ok;
  logic [7:0]           hex_c;
  logic [7:0]           ck_full;
  logic                 ck_match;

  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign c         = in_ch.rx_byte;
  assign is_dollar = (c == nmea_pkg::CHAR_DOLLAR);
  assign is_comma  = (c == nmea_pkg::CHAR_COMMA);
  assign is_star   = (c == nmea_pkg::CHAR_STAR);
  assign is_closer = is_comma || is_star;
  assign in_text   = (phase_r == nmea_pkg::PH_TYPE) || (phase_r == nmea_pkg::PH_BODY);

  assign pat_len  = (type_pattern_length_r > PAT_LEN_MAX) ? PAT_LEN_MAX
                                                           : type_pattern_length_r;
  assign pat_char = type_pattern_r[{type_pos_r[2:0], 3'b000} +: 8];

  always_comb begin
    type_ok = 1'b1;
    if ((phase_r == nmea_pkg::PH_TYPE) && type_filter_on_r) begin
      if (type_pos_r < pat_len) begin
        type_ok = !is_comma && (c == pat_char);
      end else begin
        type_ok = is_comma;
      end
    end
  end

  assign hex_c    = nmea_pkg::hex_value(c);
  assign ck_full  = received_sum_r | hex_c;
  assign ck_match = (ck_full == xor_sum_r);

  always_comb begin
    phase_nxt        = phase_r;
    xor_sum_nxt      = xor_sum_r;
    received_sum_nxt = received_sum_r;
    type_pos_nxt     = type_pos_r;
    field_tally_nxt  = field_tally_r;
    if (is_dollar) begin
      phase_nxt       = nmea_pkg::PH_TYPE;
      xor_sum_nxt     = 8'd0;
      field_tally_nxt = 6'd0;
      type_pos_nxt    = 4'd0;
    end else if (in_text) begin
      if (!type_ok) begin
        phase_nxt = nmea_pkg::PH_WAIT;
      end else begin
        if ((phase_r == nmea_pkg::PH_TYPE) && (type_pos_r < POS_MAX)) begin
          type_pos_nxt = type_pos_r + 4'd1;
        end
        if (!is_star) begin
          xor_sum_nxt = xor_sum_r ^ c;
        end
        if (is_comma) begin
          phase_nxt = nmea_pkg::PH_BODY;
        end else if (is_star) begin
          phase_nxt = nmea_pkg::PH_CK1;
        end
        if (is_closer && field_split_on_r && (field_tally_r < TALLY_MAX)) begin
          field_tally_nxt = field_tally_r + 6'd1;
        end
      end
    end else begin
      case (phase_r)
        nmea_pkg::PH_CK1: begin
          received_sum_nxt = {hex_c[3:0], 4'b0000};
          phase_nxt        = nmea_pkg::PH_CK2;
        end
        nmea_pkg::PH_CK2: begin
          received_sum_nxt = ck_full;
          phase_nxt        = nmea_pkg::PH_WAIT;
        end
        default: begin
          phase_nxt = nmea_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_comb begin
    out_data_nxt                  = '0;
    out_data_nxt.echo_byte        = c;
    out_data_nxt.fields_found     = field_tally_nxt;
    out_data_nxt.running_check    = xor_sum_nxt;
    if (is_dollar) begin
      out_data_nxt.in_sentence      = 1'b1;
      out_data_nxt.sentence_dropped = (phase_r != nmea_pkg::PH_WAIT);
    end else if (in_text) begin
      if (!type_ok) begin
        out_data_nxt.sentence_dropped = 1'b1;
      end else begin
        out_data_nxt.in_sentence  = 1'b1;
        out_data_nxt.field_number = field_split_on_r ? field_tally_r : 6'd0;
        out_data_nxt.field_closed = is_closer && field_split_on_r;
      end
    end else begin
      case (phase_r)
        nmea_pkg::PH_CK1: begin
          out_data_nxt.in_sentence  = 1'b1;
          out_data_nxt.field_number = field_tally_r;
        end
        nmea_pkg::PH_CK2: begin
          out_data_nxt.in_sentence      = 1'b1;
          out_data_nxt.field_number     = field_tally_r;
          out_data_nxt.sentence_good    = ck_match;
          out_data_nxt.sentence_dropped = !ck_match;
        end
        default: begin
          out_data_nxt.in_sentence = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_filter_on_r      <= 1'b0;
      type_pattern_r        <= 64'd0;
      type_pattern_length_r <= 4'd5;
      field_split_on_r      <= 1'b1;
    end else if (cfg_we) begin
      case (nmea_pkg::reg_idx_t'(cfg_index))
        nmea_pkg::REG_TYPE_FILTER_ON:      type_filter_on_r      <= cfg_wdata[0];
        nmea_pkg::REG_TYPE_PATTERN:        type_pattern_r        <= cfg_wdata;
        nmea_pkg::REG_TYPE_PATTERN_LENGTH: type_pattern_length_r <= cfg_wdata[3:0];
        nmea_pkg::REG_FIELD_SPLIT_ON:      field_split_on_r      <= cfg_wdata[0];
        default: begin
          type_filter_on_r <= type_filter_on_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= nmea_pkg::PH_WAIT;
      xor_sum_r      <= 8'd0;
      received_sum_r <= 8'd0;
      type_pos_r     <= 4'd0;
      field_tally_r  <= 6'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_r        <= phase_nxt;
        xor_sum_r      <= xor_sum_nxt;
        received_sum_r <= received_sum_nxt;
        type_pos_r     <= type_pos_nxt;
        field_tally_r  <= field_tally_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input stalled while the result register could take a beat");

  a_dollar_opens: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.rx_byte == nmea_pkg::CHAR_DOLLAR)) |=>
      ((phase_r == nmea_pkg::PH_TYPE) && (xor_sum_r == 8'd0) && (field_tally_r == 6'd0)))
    else $error("dollar did not open a fresh sentence");

  a_verdict_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && out_data_nxt.sentence_good) |=>
      ((phase_r == nmea_pkg::PH_WAIT) && out_valid_r && out_ch.data.sentence_good))
    else $error("good sentence did not return to waiting");

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (field_tally_r <= TALLY_MAX) && (out_ch.data.fields_found == field_tally_r))
    else $error("field count out of range or not reported");

endmodule
